[design/adr_pkg.sv]
// Shared widths, coefficients, register codes and types for the delay-line audio effect.
package adr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 15;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int STEP_W      = 3;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam int RSP_FIFO_DEPTH = 4;

   localparam int unsigned DEF_BUFFER_LENGTH = 131072;
   localparam int unsigned DEF_REVERB_UNIT   = 882;
   localparam int unsigned DEF_ECHO_UNIT     = 11025;

   // Q0.15 mix coefficients, rounded to nearest
   localparam logic [COEF_W-1:0] Q_NOW_REVERB = 15'd22938;
   localparam logic [COEF_W-1:0] Q_DEL_REVERB = 15'd9830;
   localparam logic [COEF_W-1:0] Q_NOW_ECHO   = 15'd19661;
   localparam logic [COEF_W-1:0] Q_DEL_ECHO   = 15'd13107;

   localparam logic MODE_REVERB = 1'b0;
   localparam logic MODE_ECHO   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_EFFECT_MODE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_STEP  = 4'd1;

   typedef struct packed {
      logic                wrapped;
      logic [SAMPLE_W-1:0] sample;
   } rsp_item_type;

endpackage

[design/audio_delay_echo_reverb_core.sv]
// Top level of the delay-line audio effect: feed-forward reverb or echo with feedback.
//
// Channels: req_ carries one 16-bit unsigned sample per beat; rsp_ returns one mixed
// sample per accepted beat, in order, with the buffer-wrap flag beside it. csr_ writes
// effect_mode (index 0) and delay_step (index 1); it is always ready. The user must
// write it only while the block is idle; the block does not enforce this. Writes to
// other indexes are dropped. An accepted sample moves through the stage 1 and stage 2
// registers and is then written into the result queue, which offers it on rsp_.
// Throughput: one sample per cycle while req_tready is high. Each sample costs one
// read and one write of the delay RAM; its one read and one write port set that figure.
// Hazards: a read that overlaps a write still in flight (the entry one or two samples
// ahead) is served from the write record instead of the RAM.
// Reset: control state clears synchronously and the first sample may follow at once.
// The delay RAM is not swept; entries not yet written since reset read as zero,
// tracked by the write index and a flag that sets on the first wrap.
// Stall: results wait in a 4-entry queue; req_tready drops while queued plus
// in-flight beats fill it, and rises again as rsp_ beats are taken.
module audio_delay_echo_reverb_core import adr_pkg::*; #(
   parameter int unsigned BUFFER_LENGTH = DEF_BUFFER_LENGTH,
   parameter int unsigned REVERB_UNIT   = DEF_REVERB_UNIT,
   parameter int unsigned ECHO_UNIT     = DEF_ECHO_UNIT
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [15:0] sample_in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: [15:0] sample_out, [16] buffer_wrapped, [23:17] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(BUFFER_LENGTH);
   localparam int PW     = ADDR_W + 1;
   localparam int CNT_W  = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int OCC_W  = CNT_W + 1;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(BUFFER_LENGTH - 1);
   localparam logic [PW-1:0]     BUF_LEN  = PW'(BUFFER_LENGTH);

   // ---------------------------------------------------------------- config
   logic              mode_ff, mode_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] delay_ff, delay_in;
   logic [PW-1:0]     prod_rev, prod_echo, prod_sel;
   logic              csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   always_comb begin
      mode_in = mode_ff;
      step_in = step_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_EFFECT_MODE: mode_in = csr_data[0];
            REG_DELAY_STEP:  step_in = csr_data[STEP_W-1:0];
            default:         ;
         endcase
      end
   end

   // Delay in entries; step*unit stays below twice the buffer, so one subtract wraps it.
   // Worked out at write time so the sample path only sees a register.
   assign prod_rev  = PW'(32'(step_in) * REVERB_UNIT);
   assign prod_echo = PW'(32'(step_in) * ECHO_UNIT);
   assign prod_sel  = (mode_in == MODE_ECHO) ? prod_echo : prod_rev;
   assign delay_in  = (prod_sel >= BUF_LEN) ? ADDR_W'(prod_sel - BUF_LEN)
                                            : ADDR_W'(prod_sel);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_REVERB;
         step_ff  <= '0;
         delay_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         step_ff  <= step_in;
         delay_ff <= delay_in;
      end
   end

   // ---------------------------------------------------------------- accept
   logic              req_fire;
   logic [ADDR_W-1:0] wr_idx_ff, wr_idx_in;
   logic              full_ff;
   logic [PW-1:0]     rd_diff;
   logic [ADDR_W-1:0] rd_addr;
   logic              zero_dly;
   logic              entry_ok;
   logic              wrap_now;
   logic [CNT_W-1:0]  fifo_count;
   logic [OCC_W-1:0]  occ;
   logic              s1_valid_ff, s2_valid_ff;

   // Credit check: queued results plus beats in the two mix stages.
   assign occ        = OCC_W'(fifo_count) + OCC_W'(s1_valid_ff) + OCC_W'(s2_valid_ff);
   assign req_tready = (occ < OCC_W'(RSP_FIFO_DEPTH));
   assign req_fire   = req_tvalid & req_tready;

   assign rd_diff  = {1'b0, wr_idx_ff} - {1'b0, delay_ff};
   assign rd_addr  = rd_diff[ADDR_W] ? ADDR_W'(rd_diff + BUF_LEN) : rd_diff[ADDR_W-1:0];
   assign zero_dly = (delay_ff == '0);
   // Writes go in index order from zero, so an entry holds data once the index passed it.
   assign entry_ok = full_ff || (rd_addr < wr_idx_ff);
   assign wrap_now = (wr_idx_ff == LAST_IDX);
   assign wr_idx_in = wrap_now ? '0 : wr_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         full_ff   <= 1'b0;
      end else if (req_fire) begin
         wr_idx_ff <= wr_idx_in;
         if (wrap_now) begin
            full_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [SAMPLE_W-1:0] s1_now_ff;
   logic [ADDR_W-1:0]   s1_idx_ff, s1_rd_ff;
   logic                s1_zero_ff, s1_ok_ff, s1_wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_now_ff  <= req_tdata[SAMPLE_W-1:0];
         s1_idx_ff  <= wr_idx_ff;
         s1_rd_ff   <= rd_addr;
         s1_zero_ff <= zero_dly;
         s1_ok_ff   <= entry_ok;
         s1_wrap_ff <= wrap_now;
      end
   end

   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                wrq_valid_ff;
   logic [ADDR_W-1:0]   wrq_addr_ff;
   logic [SAMPLE_W-1:0] wrq_data_ff;
   logic [SAMPLE_W-1:0] del1_in;
   logic                hit_a1_in;
   logic [COEF_W-1:0]   c_now, c_del;
   logic [PROD_W-1:0]   pnow_in;
   logic [ADDR_W-1:0]   s2_idx_ff;

   assign c_now = (mode_ff == MODE_ECHO) ? Q_NOW_ECHO : Q_NOW_REVERB;
   assign c_del = (mode_ff == MODE_ECHO) ? Q_DEL_ECHO : Q_DEL_REVERB;

   // Resolve the delayed sample: the entry itself at zero delay, then the write that
   // landed on the read edge, then unwritten entries as zero, then the RAM.
   always_comb begin
      if (s1_zero_ff) begin
         del1_in = s1_now_ff;
      end else if (wrq_valid_ff && (wrq_addr_ff == s1_rd_ff)) begin
         del1_in = wrq_data_ff;
      end else if (!s1_ok_ff) begin
         del1_in = '0;
      end else begin
         del1_in = ram_rd_data;
      end
   end

   // The beat one ahead writes after this read; take its data one stage later.
   assign hit_a1_in = s2_valid_ff && !s1_zero_ff && (s2_idx_ff == s1_rd_ff);
   assign pnow_in   = PROD_W'(32'(s1_now_ff) * 32'(c_now));

   // ---------------------------------------------------------------- stage 2
   logic [SAMPLE_W-1:0] s2_now_ff, s2_del_ff;
   logic                s2_wrap_ff, s2_hit_ff;
   logic [PROD_W-1:0]   s2_pnow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_now_ff  <= s1_now_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_wrap_ff <= s1_wrap_ff;
         s2_del_ff  <= del1_in;
         s2_hit_ff  <= hit_a1_in;
         s2_pnow_ff <= pnow_in;
      end
   end

   logic [SAMPLE_W-1:0] del2;
   logic [PROD_W-1:0]   pdel;
   logic [PROD_W:0]     mix_sum;
   logic [PROD_W-COEF_W:0] mix_raw;
   logic [SAMPLE_W-1:0] mix;
   logic [SAMPLE_W-1:0] wr_data;

   assign del2    = s2_hit_ff ? wrq_data_ff : s2_del_ff;
   assign pdel    = PROD_W'(32'(del2) * 32'(c_del));
   assign mix_sum = {1'b0, s2_pnow_ff} + {1'b0, pdel};
   assign mix_raw = mix_sum[PROD_W:COEF_W];
   // Truncate, then clamp anything past full scale
   assign mix     = mix_raw[SAMPLE_W] ? {SAMPLE_W{1'b1}} : mix_raw[SAMPLE_W-1:0];
   // Echo feeds the mix back into the line; reverb keeps the dry sample
   assign wr_data = (mode_ff == MODE_ECHO) ? mix : s2_now_ff;

   // Record of the write on this edge, for reads that overlap it.
   always_ff @(posedge clock) begin
      if (reset) begin
         wrq_valid_ff <= 1'b0;
      end else begin
         wrq_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         wrq_addr_ff <= s2_idx_ff;
         wrq_data_ff <= wr_data;
      end
   end

   adr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BUFFER_LENGTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_idx_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- results
   rsp_item_type push_item, pop_item;

   assign push_item.wrapped = s2_wrap_ff;
   assign push_item.sample  = mix;

   adr_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s2_valid_ff),
      .push_item  (push_item),
      .count      (fifo_count),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_item   (pop_item)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-SAMPLE_W-1){1'b0}}, pop_item.wrapped, pop_item.sample};

   // ---------------------------------------------------------------- checks
   a_credit: assert property (@(posedge clock) disable iff (reset)
      occ <= OCC_W'(RSP_FIFO_DEPTH))
      else $error("result queue overcommitted");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wr_idx_ff} < BUF_LEN)
      else $error("write index past buffer end");

   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ({1'b0, rd_addr} < BUF_LEN))
      else $error("read address past buffer end");

   a_full_on_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && wrap_now) |=> (full_ff && (wr_idx_ff == '0)))
      else $error("wrap did not mark buffer filled");

endmodule

[design/adr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module adr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/adr_rsp_fifo.sv]
// Small result queue that decouples the mix pipeline from the result channel.
module adr_rsp_fifo import adr_pkg::*; #(
   parameter int DEPTH = RSP_FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  rsp_item_type               push_item,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output rsp_item_type               pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign count     = count_ff;
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

endmodule
